// ===== rtl/core/sllod_pkg.sv =====
// ============================================================================
// sllod_pkg: shared types and constants for the SLLOD update unit
// Word formats, register and slot codes, coefficient bundle, pipeline word.
// ============================================================================
package sllod_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int WORD_W        = 64;
    localparam int TAB_DEPTH     = 20;
    localparam int SLOT_W        = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int SETTLE_CYCLES = 6;

    localparam int SLOT_RATE = 0;
    localparam int SLOT_XFAC = 6;
    localparam int SLOT_VFAC = 9;
    localparam int SLOT_MID  = 12;
    localparam int SLOT_LO   = 15;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PSLLOD    = 2'd0,
        CFG_HALF_STEP = 2'd1,
        CFG_FULL_STEP = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_ATOM = 1'b1
    } t_action;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] coef_index;
        t_word             coef_value;
        logic              in_group;
        t_word             pos_x;
        t_word             pos_y;
        t_word             pos_z;
        t_word             vel_x;
        t_word             vel_y;
        t_word             vel_z;
    } t_in_word;

    typedef struct packed {
        t_word new_pos_x;
        t_word new_pos_y;
        t_word new_pos_z;
        t_word new_vel_x;
        t_word new_vel_y;
        t_word new_vel_z;
    } t_out_word;

    // datapath coefficients; user keeps them constant with atoms in flight
    typedef struct packed {
        t_word dh;
        t_word fs;
        t_word h4;
        t_word h5;
        t_word c3;
        t_word cp0;
        t_word cp1;
        t_word cp2;
        t_word vf0;
        t_word vf1;
        t_word vf2;
        t_word xf0;
        t_word xf1;
        t_word xf2;
        t_word mid0;
        t_word mid1;
        t_word mid2;
        t_word lo1;
        t_word lo2;
        t_word lo3;
        t_word lo4;
    } t_coef;

    typedef struct packed {
        t_word x0;
        t_word x1;
        t_word x2;
        t_word v0;
        t_word v1;
        t_word v2;
        t_word t0;
        t_word t1;
        t_word t2;
        t_word t3;
        logic  grp;
        logic  vld;
    } t_st;

endpackage

// ===== rtl/core/sllod_in_if.sv =====
// ============================================================================
// sllod_in_if: input channel
// Valid/ready channel carrying load and atom words.
// ============================================================================
interface sllod_in_if;
    logic               valid;
    logic               ready;
    sllod_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sllod_out_if.sv =====
// ============================================================================
// sllod_out_if: result channel
// Valid/ready channel carrying updated atom words.
// ============================================================================
interface sllod_out_if;
    logic                valid;
    logic                ready;
    sllod_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sllod_fxmul.sv =====
// ============================================================================
// sllod_fxmul: pipelined fixed-point multiplier
// 64x64 signed product from four partial products, floor shift, wrap.
// Two register stages.
// ============================================================================
module sllod_fxmul #(
    parameter int FRAC_BITS = sllod_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  sllod_pkg::t_word i_a,
    input  sllod_pkg::t_word i_b,
    output sllod_pkg::t_word o_p
);

    localparam int W  = sllod_pkg::WORD_W;
    localparam int HW = W / 2;

    logic signed [W-1:0] r_hh;
    logic signed [W:0]   r_hl;
    logic signed [W:0]   r_lh;
    logic [W-1:0]        r_ll;
    logic [2*W-1:0]      w_sum;

    assign w_sum = {r_hh, {W{1'b0}}}
                 + {{(HW-1){r_hl[W]}}, r_hl, {HW{1'b0}}}
                 + {{(HW-1){r_lh[W]}}, r_lh, {HW{1'b0}}}
                 + {{W{1'b0}}, r_ll};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= $signed(i_a[W-1:HW]) * $signed(i_b[W-1:HW]);
            r_hl <= $signed(i_a[W-1:HW]) * $signed({1'b0, i_b[HW-1:0]});
            r_lh <= $signed({1'b0, i_a[HW-1:0]}) * $signed(i_b[W-1:HW]);
            r_ll <= i_a[HW-1:0] * i_b[HW-1:0];
            o_p  <= w_sum[FRAC_BITS +: W];
        end
    end

endmodule

// ===== rtl/core/sllod_dly.sv =====
// ============================================================================
// sllod_dly: enabled delay line
// Carries a pipeline word alongside a multiplier.
// ============================================================================
module sllod_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);

    logic [WIDTH-1:0] r_sh [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_sh[k] <= '0;
            end
        end else if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_d = r_sh[DEPTH-1];

endmodule

// ===== rtl/core/sllod_coef.sv =====
// ============================================================================
// sllod_coef: registers, coefficient table and derived coefficients
// Holds step sizes, the 20-word table and the products that depend only on
// them; flags when the derived products have settled.
// ============================================================================
module sllod_coef #(
    parameter int FRAC_BITS = sllod_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sllod_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  sllod_pkg::t_word                    i_cfg_data,
    input  logic                                i_load,
    input  logic [sllod_pkg::SLOT_W-1:0]        i_slot,
    input  sllod_pkg::t_word                    i_value,
    output sllod_pkg::t_coef                    o_coef,
    output logic                                o_settled
);

    localparam int SET_W = $clog2(sllod_pkg::SETTLE_CYCLES + 1);

    sllod_pkg::t_word r_tab [sllod_pkg::TAB_DEPTH];
    logic             r_ps;
    sllod_pkg::t_word r_half;
    sllod_pkg::t_word r_full;
    logic [SET_W-1:0] r_settle;
    sllod_pkg::t_word r_cp0, r_cp1, r_cp2;
    sllod_pkg::t_word w_c3, w_q0, w_q1, w_q2, w_cp0, w_cp1, w_cp2;

    always_ff @(posedge i_clk) begin
        if (i_load && i_slot < sllod_pkg::SLOT_W'(sllod_pkg::TAB_DEPTH)) begin
            r_tab[i_slot] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps     <= 1'b0;
            r_half   <= '0;
            r_full   <= '0;
            r_settle <= SET_W'(sllod_pkg::SETTLE_CYCLES);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sllod_pkg::CFG_PSLLOD:    r_ps   <= i_cfg_data[0];
                    sllod_pkg::CFG_HALF_STEP: r_half <= i_cfg_data;
                    sllod_pkg::CFG_FULL_STEP: r_full <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cfg_we || i_load) begin
                r_settle <= SET_W'(sllod_pkg::SETTLE_CYCLES);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SET_W'(1);
            end
        end
    end

    sllod_fxmul #(.FRAC_BITS(FRAC_BITS)) u_c3 (
        .i_clk(i_clk), .i_en(1'b1), .i_a(r_half),
        .i_b(r_tab[sllod_pkg::SLOT_RATE+3]), .o_p(w_c3));
    sllod_fxmul #(.FRAC_BITS(FRAC_BITS)) u_q0 (
        .i_clk(i_clk), .i_en(1'b1), .i_a(r_half),
        .i_b(r_tab[sllod_pkg::SLOT_RATE+0]), .o_p(w_q0));
    sllod_fxmul #(.FRAC_BITS(FRAC_BITS)) u_p0 (
        .i_clk(i_clk), .i_en(1'b1), .i_a(w_q0),
        .i_b(r_tab[sllod_pkg::SLOT_RATE+0]), .o_p(w_cp0));
    sllod_fxmul #(.FRAC_BITS(FRAC_BITS)) u_q1 (
        .i_clk(i_clk), .i_en(1'b1), .i_a(r_half),
        .i_b(r_tab[sllod_pkg::SLOT_RATE+1]), .o_p(w_q1));
    sllod_fxmul #(.FRAC_BITS(FRAC_BITS)) u_p1 (
        .i_clk(i_clk), .i_en(1'b1), .i_a(w_q1),
        .i_b(r_tab[sllod_pkg::SLOT_RATE+1]), .o_p(w_cp1));
    sllod_fxmul #(.FRAC_BITS(FRAC_BITS)) u_q2 (
        .i_clk(i_clk), .i_en(1'b1), .i_a(r_half),
        .i_b(r_tab[sllod_pkg::SLOT_RATE+2]), .o_p(w_q2));
    sllod_fxmul #(.FRAC_BITS(FRAC_BITS)) u_p2 (
        .i_clk(i_clk), .i_en(1'b1), .i_a(w_q2),
        .i_b(r_tab[sllod_pkg::SLOT_RATE+2]), .o_p(w_cp2));

    // diagonal terms vanish in plain mode
    always_ff @(posedge i_clk) begin
        r_cp0 <= r_ps ? w_cp0 : '0;
        r_cp1 <= r_ps ? w_cp1 : '0;
        r_cp2 <= r_ps ? w_cp2 : '0;
    end

    always_comb begin
        o_coef.dh   = r_half;
        o_coef.fs   = r_full;
        o_coef.h4   = r_tab[sllod_pkg::SLOT_RATE+4];
        o_coef.h5   = r_tab[sllod_pkg::SLOT_RATE+5];
        o_coef.c3   = w_c3;
        o_coef.cp0  = r_cp0;
        o_coef.cp1  = r_cp1;
        o_coef.cp2  = r_cp2;
        o_coef.vf0  = r_tab[sllod_pkg::SLOT_VFAC+0];
        o_coef.vf1  = r_tab[sllod_pkg::SLOT_VFAC+1];
        o_coef.vf2  = r_tab[sllod_pkg::SLOT_VFAC+2];
        o_coef.xf0  = r_tab[sllod_pkg::SLOT_XFAC+0];
        o_coef.xf1  = r_tab[sllod_pkg::SLOT_XFAC+1];
        o_coef.xf2  = r_tab[sllod_pkg::SLOT_XFAC+2];
        o_coef.mid0 = r_tab[sllod_pkg::SLOT_MID+0];
        o_coef.mid1 = r_tab[sllod_pkg::SLOT_MID+1];
        o_coef.mid2 = r_tab[sllod_pkg::SLOT_MID+2];
        o_coef.lo1  = r_tab[sllod_pkg::SLOT_LO+1];
        o_coef.lo2  = r_tab[sllod_pkg::SLOT_LO+2];
        o_coef.lo3  = r_tab[sllod_pkg::SLOT_LO+3];
        o_coef.lo4  = r_tab[sllod_pkg::SLOT_LO+4];
    end

    assign o_settled = (r_settle == '0);

endmodule

// ===== rtl/core/sllod_atom_position_velocity_update_unit.sv =====
// ============================================================================
// sllod_atom_position_velocity_update_unit: reversible SLLOD step per atom
// Streams atoms through a ten-level multiply pipeline; load words fill the
// coefficient table.
// ============================================================================
// Takes one atom word per cycle while the output is not stalled and the
// coefficients have settled. Every 64x64 product runs through a two-stage
// multiplier made of four partial products, and each multiply level is followed
// by a register of adds, giving ten levels plus input, pre-add and output
// registers. A load word is taken only once all atoms in flight have left the
// pipeline; after a load word or a register write, atoms are held off while
// the derived rate products update. Atoms outside the group pass through
// unchanged along the same pipeline.
module sllod_atom_position_velocity_update_unit #(
    parameter int FRAC_BITS = sllod_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sllod_in_if.sink                        i_atom,
    sllod_out_if.source                     o_result,
    input  logic                            i_cfg_we,
    input  logic [sllod_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  sllod_pkg::t_word                i_cfg_data
);

    localparam int MUL_LAT    = 2;
    localparam int N_LVL      = 10;
    localparam int N_MUL      = 37;
    localparam int LAST       = N_LVL + 1;
    localparam int PIPE_SLOTS = LAST + 1 + N_LVL * MUL_LAT;
    localparam int CNT_W      = $clog2(PIPE_SLOTS + 1);

    sllod_pkg::t_coef     w_c;
    logic                 w_settled;
    logic                 w_en, w_acc, w_load, w_atom, w_leave;
    logic [CNT_W-1:0]     r_cnt;
    sllod_pkg::t_st       r_b [LAST+1];
    sllod_pkg::t_st       n_b [LAST+1];
    sllod_pkg::t_st       w_d [1:N_LVL];
    sllod_pkg::t_word     w_ma [N_MUL];
    sllod_pkg::t_word     w_mb [N_MUL];
    sllod_pkg::t_word     w_mp [N_MUL];
    logic                 r_out_vld;
    sllod_pkg::t_out_word r_out;

    assign w_en   = !r_out_vld || o_result.ready || !r_b[LAST].vld;
    assign w_acc  = i_atom.valid && i_atom.ready;
    assign w_load = w_acc && (i_atom.data.action == sllod_pkg::ACT_LOAD);
    assign w_atom = w_acc && (i_atom.data.action == sllod_pkg::ACT_ATOM);
    assign w_leave = r_b[LAST].vld && (!r_out_vld || o_result.ready);

    assign i_atom.ready = w_en && ((i_atom.data.action == sllod_pkg::ACT_ATOM)
                                   ? w_settled : (r_cnt == '0));

    sllod_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_load    (w_load),
        .i_slot    (i_atom.data.coef_index),
        .i_value   (i_atom.data.coef_value),
        .o_coef    (w_c),
        .o_settled (w_settled)
    );

    for (genvar k = 1; k <= N_LVL; k++) begin : g_dly
        sllod_dly #(.WIDTH($bits(sllod_pkg::t_st)), .DEPTH(MUL_LAT)) u_dly (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_d(r_b[k]), .o_d(w_d[k]));
    end

    for (genvar i = 0; i < N_MUL; i++) begin : g_mul
        sllod_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_ma[i]), .i_b(w_mb[i]),
            .o_p(w_mp[i]));
    end

    // multiplier operands, grouped by level
    always_comb begin
        // first half: v2 diag, v1 diag, v0 diag, x1 shear
        w_ma[0]  = w_c.cp2;  w_mb[0]  = r_b[1].x2;
        w_ma[1]  = w_c.cp1;  w_mb[1]  = r_b[1].x1;
        w_ma[2]  = w_c.cp0;  w_mb[2]  = r_b[1].x0;
        w_ma[3]  = w_c.c3;   w_mb[3]  = r_b[1].t0;
        w_ma[4]  = w_c.c3;   w_mb[4]  = r_b[2].v2;
        w_ma[5]  = w_c.h4;   w_mb[5]  = r_b[2].v2;
        w_ma[6]  = w_c.h5;   w_mb[6]  = r_b[2].t0;
        w_ma[7]  = w_c.h4;   w_mb[7]  = r_b[2].t1;
        w_ma[8]  = w_c.h5;   w_mb[8]  = r_b[3].v1;
        w_ma[9]  = w_c.dh;   w_mb[9]  = r_b[3].t0;
        w_ma[10] = r_b[3].v2; w_mb[10] = w_c.vf2;
        w_ma[11] = w_c.dh;   w_mb[11] = r_b[4].t0;
        w_ma[12] = r_b[4].x0; w_mb[12] = w_c.xf0;
        w_ma[13] = r_b[4].x1; w_mb[13] = w_c.xf1;
        w_ma[14] = r_b[4].x2; w_mb[14] = w_c.xf2;
        w_ma[15] = r_b[5].v0; w_mb[15] = w_c.vf0;
        w_ma[16] = r_b[5].v1; w_mb[16] = w_c.vf1;
        // full position step
        w_ma[17] = w_c.fs;   w_mb[17] = r_b[6].v0;
        w_ma[18] = w_c.fs;   w_mb[18] = r_b[6].v1;
        w_ma[19] = w_c.fs;   w_mb[19] = r_b[6].v2;
        // second half
        w_ma[20] = r_b[7].x0; w_mb[20] = w_c.xf0;
        w_ma[21] = r_b[7].x1; w_mb[21] = w_c.xf1;
        w_ma[22] = r_b[7].x2; w_mb[22] = w_c.xf2;
        w_ma[23] = r_b[7].v0; w_mb[23] = w_c.vf0;
        w_ma[24] = r_b[7].v1; w_mb[24] = w_c.vf1;
        w_ma[25] = r_b[7].v2; w_mb[25] = w_c.vf2;
        w_ma[26] = w_c.h5;   w_mb[26] = r_b[8].t0;
        w_ma[27] = w_c.h4;   w_mb[27] = r_b[8].t1;
        w_ma[28] = w_c.c3;   w_mb[28] = r_b[8].t1;
        w_ma[29] = w_c.h5;   w_mb[29] = r_b[8].v1;
        w_ma[30] = w_c.h4;   w_mb[30] = r_b[8].v2;
        w_ma[31] = w_c.dh;   w_mb[31] = r_b[9].t0;
        w_ma[32] = w_c.dh;   w_mb[32] = r_b[9].t1;
        w_ma[33] = w_c.cp1;  w_mb[33] = r_b[9].x1;
        w_ma[34] = w_c.cp2;  w_mb[34] = r_b[9].x2;
        w_ma[35] = w_c.c3;   w_mb[35] = r_b[9].v2;
        w_ma[36] = w_c.cp0;  w_mb[36] = r_b[10].x0;
    end

    // input word, pre-add, and the add stage after each multiply level
    always_comb begin
        n_b[0].x0  = i_atom.data.pos_x;
        n_b[0].x1  = i_atom.data.pos_y;
        n_b[0].x2  = i_atom.data.pos_z;
        n_b[0].v0  = i_atom.data.vel_x;
        n_b[0].v1  = i_atom.data.vel_y;
        n_b[0].v2  = i_atom.data.vel_z;
        n_b[0].t0  = '0;
        n_b[0].t1  = '0;
        n_b[0].t2  = '0;
        n_b[0].t3  = '0;
        n_b[0].grp = i_atom.data.in_group;
        n_b[0].vld = w_atom;

        n_b[1] = r_b[0];
        n_b[1].t0 = r_b[0].x2 - w_c.lo2;

        n_b[2] = w_d[1];
        if (w_d[1].grp) begin
            n_b[2].v2 = w_d[1].v2 - w_mp[0];
            n_b[2].x1 = w_d[1].x1 + w_mp[3];
            n_b[2].t0 = w_d[1].x1 + w_mp[3] - w_c.lo1;
            n_b[2].t1 = w_d[1].t0;
            n_b[2].t2 = w_mp[1];
            n_b[2].t3 = w_mp[2];
        end

        n_b[3] = w_d[2];
        if (w_d[2].grp) begin
            n_b[3].v1 = w_d[2].v1 - (w_mp[4] + w_d[2].t2);
            n_b[3].t0 = w_mp[6] + w_mp[7];
            n_b[3].t1 = w_mp[5];
        end

        n_b[4] = w_d[3];
        if (w_d[3].grp) begin
            n_b[4].x0 = w_d[3].x0 + w_mp[9] - w_c.mid0;
            n_b[4].x1 = w_d[3].x1 - w_c.mid1;
            n_b[4].x2 = w_d[3].x2 - w_c.mid2;
            n_b[4].v2 = w_mp[10];
            n_b[4].t0 = w_mp[8] + w_d[3].t1;
        end

        n_b[5] = w_d[4];
        if (w_d[4].grp) begin
            n_b[5].v0 = w_d[4].v0 - (w_mp[11] + w_d[4].t3);
            n_b[5].x0 = w_c.mid0 + w_mp[12];
            n_b[5].x1 = w_c.mid1 + w_mp[13];
            n_b[5].x2 = w_c.mid2 + w_mp[14];
        end

        n_b[6] = w_d[5];
        if (w_d[5].grp) begin
            n_b[6].v0 = w_mp[15];
            n_b[6].v1 = w_mp[16];
        end

        n_b[7] = w_d[6];
        if (w_d[6].grp) begin
            n_b[7].x0 = w_d[6].x0 + w_mp[17] - w_c.mid0;
            n_b[7].x1 = w_d[6].x1 + w_mp[18] - w_c.mid1;
            n_b[7].x2 = w_d[6].x2 + w_mp[19] - w_c.mid2;
        end

        n_b[8] = w_d[7];
        if (w_d[7].grp) begin
            n_b[8].x0 = w_c.mid0 + w_mp[20];
            n_b[8].x1 = w_c.mid1 + w_mp[21];
            n_b[8].x2 = w_c.mid2 + w_mp[22];
            n_b[8].v0 = w_mp[23];
            n_b[8].v1 = w_mp[24];
            n_b[8].v2 = w_mp[25];
            n_b[8].t0 = w_c.mid1 + w_mp[21] - w_c.lo3;
            n_b[8].t1 = w_c.mid2 + w_mp[22] - w_c.lo4;
        end

        n_b[9] = w_d[8];
        if (w_d[8].grp) begin
            n_b[9].t0 = w_mp[26] + w_mp[27];
            n_b[9].x1 = w_d[8].x1 + w_mp[28];
            n_b[9].t1 = w_mp[29] + w_mp[30];
        end

        n_b[10] = w_d[9];
        if (w_d[9].grp) begin
            n_b[10].x0 = w_d[9].x0 + w_mp[31];
            n_b[10].t0 = w_mp[32];
            n_b[10].v1 = w_d[9].v1 - (w_mp[35] + w_mp[33]);
            n_b[10].v2 = w_d[9].v2 - w_mp[34];
        end

        n_b[11] = w_d[10];
        if (w_d[10].grp) begin
            n_b[11].v0 = w_d[10].v0 - (w_d[10].t0 + w_mp[36]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_b[k] <= '0;
            end
        end else if (w_en) begin
            for (int k = 0; k <= LAST; k++) begin
                r_b[k] <= n_b[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(w_atom) - CNT_W'(w_leave);
            if (!r_out_vld || o_result.ready) begin
                r_out_vld <= r_b[LAST].vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || o_result.ready) begin
            r_out.new_pos_x <= r_b[LAST].x0;
            r_out.new_pos_y <= r_b[LAST].x1;
            r_out.new_pos_z <= r_b[LAST].x2;
            r_out.new_vel_x <= r_b[LAST].v0;
            r_out.new_vel_y <= r_b[LAST].v1;
            r_out.new_vel_z <= r_b[LAST].v2;
        end
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> r_cnt == '0)
        else $error("load word taken with atoms in flight");

    a_atom_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_atom |-> w_settled)
        else $error("atom taken before coefficients settled");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_SLOTS))
        else $error("in-flight count exceeds pipeline slots");

    a_empty_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (!r_b[LAST].vld && !r_b[0].vld))
        else $error("valid word in pipeline while count is zero");

endmodule

// ===== verif/sllod_atom_position_velocity_update_unit_tb.sv =====
// ============================================================================
// sllod_atom_position_velocity_update_unit_tb: self-checking bench
// Fills the coefficient table, runs a directed table and random load/atom
// words under several register settings with random gaps and stalls on both
// channels, and checks every result word against a built-in SLLOD predictor.
// ============================================================================
`timescale 1ns / 1ps

module sllod_atom_position_velocity_update_unit_tb;

    localparam int FRAC        = sllod_pkg::FRAC_BITS_DEF;
    localparam int N_PHASES    = 6;
    localparam int RAND_ITEMS  = 125;
    localparam int DRAIN_WAIT  = 33 + sllod_pkg::SETTLE_CYCLES + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IN_W        = $bits(sllod_pkg::t_in_word);
    localparam int IDX_W       = sllod_pkg::SLOT_W;

    typedef struct {
        sllod_pkg::t_in_word  w;
        bit                   has_exp;
        sllod_pkg::t_out_word exp_w;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [sllod_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    sllod_pkg::t_word i_cfg_data = '0;

    sllod_in_if  atom_ch();
    sllod_out_if result_ch();

    sllod_atom_position_velocity_update_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_atom    (atom_ch.sink),
        .o_result  (result_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // predictor state
    sllod_pkg::t_word coef_tab [sllod_pkg::TAB_DEPTH];
    bit               pmode;
    sllod_pkg::t_word half_dt, full_dt;

    sllod_pkg::t_out_word pending_q[$];
    t_row                 dir_rows[$];
    int  n_fail = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;
    int  stall_cnt = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic sllod_pkg::t_word fxm(sllod_pkg::t_word a, sllod_pkg::t_word b);
        logic signed [127:0] pa, pb, pr;
        pa = a;
        pb = b;
        pr = pa * pb;
        pr = pr >>> FRAC;
        return pr[63:0];
    endfunction

    function automatic sllod_pkg::t_word about(sllod_pkg::t_word p, sllod_pkg::t_word c,
                                               sllod_pkg::t_word f);
        return c + fxm(p - c, f);
    endfunction

    function automatic sllod_pkg::t_out_word sllod_step(sllod_pkg::t_in_word w);
        sllod_pkg::t_out_word r;
        sllod_pkg::t_word x0, x1, x2, v0, v1, v2, dh;
        sllod_pkg::t_word h[6];
        sllod_pkg::t_word vf[3], xf[3], mid[3], lo[5];
        x0 = w.pos_x; x1 = w.pos_y; x2 = w.pos_z;
        v0 = w.vel_x; v1 = w.vel_y; v2 = w.vel_z;
        dh = half_dt;
        for (int k = 0; k < 6; k++) h[k] = coef_tab[sllod_pkg::SLOT_RATE + k];
        for (int k = 0; k < 3; k++) begin
            vf[k]  = coef_tab[sllod_pkg::SLOT_VFAC + k];
            xf[k]  = coef_tab[sllod_pkg::SLOT_XFAC + k];
            mid[k] = coef_tab[sllod_pkg::SLOT_MID + k];
        end
        for (int k = 0; k < 5; k++) lo[k] = coef_tab[sllod_pkg::SLOT_LO + k];
        if (w.in_group) begin
            if (pmode) begin
                v2 -= fxm(fxm(fxm(dh, h[2]), h[2]), x2);
                v1 -= fxm(fxm(dh, h[3]), v2) + fxm(fxm(fxm(dh, h[1]), h[1]), x1);
                v0 -= fxm(dh, fxm(h[5], v1) + fxm(h[4], v2))
                      + fxm(fxm(fxm(dh, h[0]), h[0]), x0);
            end else begin
                v1 -= fxm(fxm(dh, h[3]), v2);
                v0 -= fxm(dh, fxm(h[5], v1) + fxm(h[4], v2));
            end
            v0 = fxm(v0, vf[0]);
            v1 = fxm(v1, vf[1]);
            v2 = fxm(v2, vf[2]);

            x1 += fxm(fxm(dh, h[3]), x2 - lo[2]);
            x0 += fxm(dh, fxm(h[5], x1 - lo[1]) + fxm(h[4], x2 - lo[2]));
            x0 = about(x0, mid[0], xf[0]);
            x1 = about(x1, mid[1], xf[1]);
            x2 = about(x2, mid[2], xf[2]);

            x0 += fxm(full_dt, v0);
            x1 += fxm(full_dt, v1);
            x2 += fxm(full_dt, v2);

            x0 = about(x0, mid[0], xf[0]);
            x1 = about(x1, mid[1], xf[1]);
            x2 = about(x2, mid[2], xf[2]);
            x0 += fxm(dh, fxm(h[5], x1 - lo[3]) + fxm(h[4], x2 - lo[4]));
            x1 += fxm(fxm(dh, h[3]), x2 - lo[4]);

            v0 = fxm(v0, vf[0]);
            v1 = fxm(v1, vf[1]);
            v2 = fxm(v2, vf[2]);
            if (pmode) begin
                v0 -= fxm(dh, fxm(h[5], v1) + fxm(h[4], v2))
                      + fxm(fxm(fxm(dh, h[0]), h[0]), x0);
                v1 -= fxm(fxm(dh, h[3]), v2) + fxm(fxm(fxm(dh, h[1]), h[1]), x1);
                v2 -= fxm(fxm(fxm(dh, h[2]), h[2]), x2);
            end else begin
                v0 -= fxm(dh, fxm(h[5], v1) + fxm(h[4], v2));
                v1 -= fxm(fxm(dh, h[3]), v2);
            end
        end
        r.new_pos_x = x0; r.new_pos_y = x1; r.new_pos_z = x2;
        r.new_vel_x = v0; r.new_vel_y = v1; r.new_vel_z = v2;
        return r;
    endfunction

    // mostly values near unity, some full-range, some extremes
    function automatic sllod_pkg::t_word rnd_word();
        sllod_pkg::t_word v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = {$urandom, $urandom};
            3: begin
                case ($urandom_range(0, 3))
                    0: v = {1'b0, {63{1'b1}}};
                    1: v = {1'b1, {63{1'b0}}};
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = sllod_pkg::t_word'($signed({$urandom_range(0, 3), $urandom}))
                         - (64'sd2 <<< FRAC);
        endcase
        return v;
    endfunction

    function automatic sllod_pkg::t_in_word load_word(int idx, sllod_pkg::t_word val);
        sllod_pkg::t_in_word w;
        w = '0;
        w.action = sllod_pkg::ACT_LOAD;
        w.coef_index = idx[IDX_W-1:0];
        w.coef_value = val;
        return w;
    endfunction

    function automatic sllod_pkg::t_in_word atom_word(bit grp,
            sllod_pkg::t_word px, sllod_pkg::t_word py, sllod_pkg::t_word pz,
            sllod_pkg::t_word vx, sllod_pkg::t_word vy, sllod_pkg::t_word vz);
        sllod_pkg::t_in_word w;
        w = '0;
        w.action = sllod_pkg::ACT_ATOM;
        w.in_group = grp;
        w.pos_x = px; w.pos_y = py; w.pos_z = pz;
        w.vel_x = vx; w.vel_y = vy; w.vel_z = vz;
        return w;
    endfunction

    function automatic sllod_pkg::t_in_word rnd_item();
        sllod_pkg::t_in_word w;
        w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) < 2) begin
            w.action = sllod_pkg::ACT_LOAD;
            w.coef_index = ($urandom_range(0, 9) == 0)
                           ? IDX_W'($urandom_range(sllod_pkg::TAB_DEPTH, 31))
                           : IDX_W'($urandom_range(0, sllod_pkg::TAB_DEPTH-1));
            w.coef_value = rnd_word();
        end else begin
            w.action = sllod_pkg::ACT_ATOM;
            w.in_group = ($urandom_range(0, 3) != 0);
            w.pos_x = rnd_word(); w.pos_y = rnd_word(); w.pos_z = rnd_word();
            w.vel_x = rnd_word(); w.vel_y = rnd_word(); w.vel_z = rnd_word();
        end
        return w;
    endfunction

    function automatic sllod_pkg::t_out_word echo_word(sllod_pkg::t_in_word w);
        sllod_pkg::t_out_word r;
        r.new_pos_x = w.pos_x; r.new_pos_y = w.pos_y; r.new_pos_z = w.pos_z;
        r.new_vel_x = w.vel_x; r.new_vel_y = w.vel_y; r.new_vel_z = w.vel_z;
        return r;
    endfunction

    // called just after the clock rises; returns just after the accepting edge
    task automatic send_word(sllod_pkg::t_in_word w, bit has_exp,
                             sllod_pkg::t_out_word exp_w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            atom_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        atom_ch.valid <= 1'b1;
        atom_ch.data  <= w;
        do @(posedge i_clk); while (!atom_ch.ready);
        if (w.action == sllod_pkg::ACT_LOAD) begin
            if (w.coef_index < sllod_pkg::TAB_DEPTH) coef_tab[w.coef_index] = w.coef_value;
        end else begin
            pending_q.push_back(has_exp ? exp_w : sllod_step(w));
        end
    endtask

    task automatic write_reg(sllod_pkg::t_cfg_idx idx, sllod_pkg::t_word val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            sllod_pkg::CFG_PSLLOD:    pmode = val[0];
            sllod_pkg::CFG_HALF_STEP: half_dt = val;
            default:                  full_dt = val;
        endcase
    endtask

    task automatic wait_drained();
        atom_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // result side: random stall per word, compare at each accepting edge
    always @(posedge i_clk) begin
        sllod_pkg::t_out_word got, want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.data;
            if (pending_q.size() == 0) begin
                $error("unexpected result word %h", got);
                n_fail++;
            end else begin
                want = pending_q.pop_front();
                if (got.new_pos_x !== want.new_pos_x) begin
                    $error("new_pos_x exp %h got %h", want.new_pos_x, got.new_pos_x); n_fail++;
                end
                if (got.new_pos_y !== want.new_pos_y) begin
                    $error("new_pos_y exp %h got %h", want.new_pos_y, got.new_pos_y); n_fail++;
                end
                if (got.new_pos_z !== want.new_pos_z) begin
                    $error("new_pos_z exp %h got %h", want.new_pos_z, got.new_pos_z); n_fail++;
                end
                if (got.new_vel_x !== want.new_vel_x) begin
                    $error("new_vel_x exp %h got %h", want.new_vel_x, got.new_vel_x); n_fail++;
                end
                if (got.new_vel_y !== want.new_vel_y) begin
                    $error("new_vel_y exp %h got %h", want.new_vel_y, got.new_vel_y); n_fail++;
                end
                if (got.new_vel_z !== want.new_vel_z) begin
                    $error("new_vel_z exp %h got %h", want.new_vel_z, got.new_vel_z); n_fail++;
                end
            end
            stall_cnt = no_idle ? 0 : $urandom_range(0, 16);
        end
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        sllod_pkg::t_word one, mx, mn;
        t_row             r;
        atom_ch.valid <= 1'b0;
        atom_ch.data  <= '0;
        one = 64'sd1 <<< FRAC;
        mx  = {1'b0, {63{1'b1}}};
        mn  = {1'b1, {63{1'b0}}};
        for (int k = 0; k < sllod_pkg::TAB_DEPTH; k++) coef_tab[k] = '0;
        pmode = 1'b0; half_dt = '0; full_dt = '0;

        // directed: fill every slot, one out-of-range load, then edge-case atoms
        for (int k = 0; k < sllod_pkg::TAB_DEPTH; k++) begin
            r.has_exp = 1'b0;
            r.w = load_word(k, (k >= sllod_pkg::SLOT_XFAC && k < sllod_pkg::SLOT_MID) ? one
                               : (k == 0 ? mx : (k == 1 ? mn : rnd_word())));
            dir_rows.push_back(r);
        end
        r.w = load_word(31, mx); r.has_exp = 1'b0; dir_rows.push_back(r);
        r.w = atom_word(1'b0, mx, mn, '0, '1, mx, mn);
        r.has_exp = 1'b1; r.exp_w = echo_word(r.w); dir_rows.push_back(r);
        r.w = atom_word(1'b0, mn, mx, '1, '0, mn, mx);
        r.exp_w = echo_word(r.w); dir_rows.push_back(r);
        r.has_exp = 1'b0;
        r.w = atom_word(1'b1, mx, mx, mx, mx, mx, mx); dir_rows.push_back(r);
        r.w = atom_word(1'b1, mn, mn, mn, mn, mn, mn); dir_rows.push_back(r);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            no_idle = (ph == 2);
            write_reg(sllod_pkg::CFG_PSLLOD, sllod_pkg::t_word'(ph % 2));
            case (ph)
                1: begin
                    write_reg(sllod_pkg::CFG_HALF_STEP, mx);
                    write_reg(sllod_pkg::CFG_FULL_STEP, mn);
                end
                3: begin
                    write_reg(sllod_pkg::CFG_HALF_STEP, mn);
                    write_reg(sllod_pkg::CFG_FULL_STEP, mx);
                end
                4: begin
                    write_reg(sllod_pkg::CFG_HALF_STEP, '0);
                    write_reg(sllod_pkg::CFG_FULL_STEP, '0);
                end
                default: begin
                    write_reg(sllod_pkg::CFG_HALF_STEP,
                              sllod_pkg::t_word'($signed($urandom)) >>> 2);
                    write_reg(sllod_pkg::CFG_FULL_STEP,
                              sllod_pkg::t_word'($signed($urandom)) >>> 1);
                end
            endcase
            i_cfg_we <= 1'b0;
            if (ph == 0) begin
                foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].has_exp,
                                                dir_rows[i].exp_w);
            end
            for (int n = 0; n < RAND_ITEMS; n++) send_word(rnd_item(), 1'b0, '0);
            wait_drained();
        end

        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
